// File: hdl/voxel_exposed_face_tracker_defines.svh
// Assertion macros shared by the checker of the voxel exposed-face tracker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef VOXEL_EXPOSED_FACE_TRACKER_DEFINES_SVH
`define VOXEL_EXPOSED_FACE_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VEFT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VEFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/veft_pkg.sv
// Package for the voxel exposed-face tracker: grid sizes, field widths, codes,
// transaction types and the neighbour and address helpers. No dependencies.
`default_nettype none

package veft_pkg;

  localparam int DIM_X = 32;
  localparam int DIM_Y = 32;
  localparam int DIM_Z = 32;
  localparam int DEPTH = DIM_X * DIM_Y * DIM_Z;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int CMD_W = 2;
  localparam int COORD_W = 5;
  localparam int NB_W = COORD_W + 1;
  localparam int FACE_W = 6;
  localparam int WORD_W = FACE_W + 1;
  localparam int EXT_W = 6;
  localparam int REG_IDX_W = 2;
  localparam int DIR_W = 3;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CARVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic KIND_VISIBLE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;
  localparam logic [EXT_W-1:0] EXTENT_RESET = 6'd32;

  localparam logic [DIR_W-1:0] DIR_NX = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PX = 3'd1;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;
  localparam logic [DIR_W-1:0] DIR_DONE = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_z;
    logic [FACE_W-1:0]  faces;
    logic               solid;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic            ok;
    logic [NB_W-1:0] x;
    logic [NB_W-1:0] y;
    logic [NB_W-1:0] z;
  } nb_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_TGT,
    ST_NB,
    ST_FINISH
  } state_t;

  function automatic int eff_extent(input logic [EXT_W-1:0] e, input int dim);
    return (int'(e) > dim) ? dim : int'(e);
  endfunction

  function automatic logic in_range(input logic [NB_W-1:0] x, input logic [NB_W-1:0] y,
                                    input logic [NB_W-1:0] z, input logic [EXT_W-1:0] ex,
                                    input logic [EXT_W-1:0] ey,
                                    input logic [EXT_W-1:0] ez);
    return (int'(x) < eff_extent(ex, DIM_X)) && (int'(y) < eff_extent(ey, DIM_Y)) &&
           (int'(z) < eff_extent(ez, DIM_Z));
  endfunction

  function automatic logic [ADDR_W-1:0] vox_addr(input logic [NB_W-1:0] x,
                                                 input logic [NB_W-1:0] y,
                                                 input logic [NB_W-1:0] z);
    return ADDR_W'((int'(z) * DIM_Y + int'(y)) * DIM_X + int'(x));
  endfunction

  function automatic nb_t nb_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                   input logic [COORD_W-1:0] z, input logic [DIR_W-1:0] d);
    nb_t r;
    r.ok = 1'b1;
    r.x = {1'b0, x};
    r.y = {1'b0, y};
    r.z = {1'b0, z};
    case (d)
      DIR_NX: begin
        r.ok = (x != '0);
        r.x = r.x - NB_W'(1);
      end
      DIR_PX: r.x = r.x + NB_W'(1);
      DIR_PY: r.y = r.y + NB_W'(1);
      DIR_NY: begin
        r.ok = (y != '0);
        r.y = r.y - NB_W'(1);
      end
      DIR_PZ: r.z = r.z + NB_W'(1);
      DIR_NZ: begin
        r.ok = (z != '0);
        r.z = r.z - NB_W'(1);
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [FACE_W-1:0] own_bit(input logic [DIR_W-1:0] d);
    return FACE_W'(1) << d;
  endfunction

  // The facing side of a neighbour is the paired direction: -x/+x, +y/-y, +z/-z.
  function automatic logic [FACE_W-1:0] far_bit(input logic [DIR_W-1:0] d);
    return FACE_W'(1) << (d ^ DIR_W'(1));
  endfunction

endpackage

`default_nettype wire

// File: hdl/voxel_exposed_face_tracker.sv
// Top level of the voxel exposed-face tracker: sequencer, configuration
// registers and output register. Depends on veft_pkg and veft_ram.
//
//   Channel   Signals                          Direction  Payload
//   request   req_valid, req_stall, req        in         req_t
//   response  rsp_valid, rsp_stall, rsp        out        rsp_t
//   config    cfg_we, cfg_index, cfg_data      in         extent registers
//
// After reset a clearing pass writes every one of the DEPTH grid entries;
// req_stall stays high until it ends.
// Adds and carves walk over the six neighbours, one grid memory read per cycle
// overlapped with the write-back, unless a stalled response holds the walk.
// A stalled response holds the sequencer only when it has a new result to hand over.
`default_nettype none

module voxel_exposed_face_tracker
  import veft_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output      logic                 req_stall,
  input  wire req_t                 req,
  output      logic                 rsp_valid,
  input  wire logic                 rsp_stall,
  output      rsp_t                 rsp,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [EXT_W-1:0]     cfg_data
);

  state_t state, state_next;
  req_t item, item_next;
  logic [DIR_W-1:0] dir, dir_next;
  logic [DIR_W-1:0] pdir, pdir_next;
  logic rd_pend, rd_pend_next;
  logic [FACE_W-1:0] mask, mask_next;
  logic [WORD_W-1:0] cur, cur_next;
  logic pend_valid, pend_valid_next;
  rsp_t pend, pend_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [EXT_W-1:0] ext_x, ext_y, ext_z;

  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic push, can_emit, blocked;
  rsp_t push_data, found;
  nb_t nb, pnb;
  logic nb_ok, tgt_ok, nb_solid;
  logic [ADDR_W-1:0] tgt_addr;
  logic [FACE_W-1:0] proc_bits, issue_bits;

  veft_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign can_emit = !rsp_valid || !rsp_stall;
  assign tgt_ok = in_range({1'b0, item.pos_x}, {1'b0, item.pos_y}, {1'b0, item.pos_z},
                           ext_x, ext_y, ext_z);
  assign tgt_addr = vox_addr({1'b0, item.pos_x}, {1'b0, item.pos_y}, {1'b0, item.pos_z});
  assign nb = nb_coord(item.pos_x, item.pos_y, item.pos_z, dir);
  assign nb_ok = nb.ok && in_range(nb.x, nb.y, nb.z, ext_x, ext_y, ext_z);
  assign pnb = nb_coord(item.pos_x, item.pos_y, item.pos_z, pdir);
  assign nb_solid = ram_rdata[FACE_W];

  always_comb begin
    found.kind = KIND_VISIBLE;
    found.out_x = pnb.x[COORD_W-1:0];
    found.out_y = pnb.y[COORD_W-1:0];
    found.out_z = pnb.z[COORD_W-1:0];
    found.faces = ram_rdata[FACE_W-1:0] | far_bit(pdir);
    found.solid = 1'b1;
    found.last = 1'b0;
  end

  always_comb begin
    state_next = state;
    item_next = item;
    dir_next = dir;
    pdir_next = pdir;
    rd_pend_next = rd_pend;
    mask_next = mask;
    cur_next = cur;
    pend_valid_next = pend_valid;
    pend_next = pend;
    clr_addr_next = clr_addr;
    ram_we = 1'b0;
    ram_waddr = tgt_addr;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = tgt_addr;
    push = 1'b0;
    push_data = '0;
    req_stall = 1'b1;
    blocked = 1'b0;
    proc_bits = '0;
    issue_bits = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          item_next = req;
          state_next = ST_START;
        end
      end

      ST_START: begin
        dir_next = DIR_NX;
        rd_pend_next = 1'b0;
        mask_next = '0;
        pend_valid_next = 1'b0;
        case (item.cmd)
          CMD_READ: begin
            if (tgt_ok) begin
              ram_re = 1'b1;
              state_next = ST_TGT;
            end else begin
              cur_next = '0;
              state_next = ST_FINISH;
            end
          end
          CMD_ADD: begin
            if (tgt_ok) begin
              ram_re = 1'b1;
              state_next = ST_TGT;
            end else begin
              state_next = ST_IDLE;
            end
          end
          CMD_CARVE: begin
            if (tgt_ok) begin
              ram_we = 1'b1;
              state_next = ST_NB;
            end else begin
              state_next = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end

      ST_TGT: begin
        cur_next = ram_rdata;
        state_next = (item.cmd == CMD_READ) ? ST_FINISH : ST_NB;
      end

      ST_NB: begin
        // Process the pending neighbour read while the next one is read.
        if (rd_pend && nb_solid && item.cmd == CMD_CARVE &&
            ram_rdata[FACE_W-1:0] == '0 && pend_valid && !can_emit) begin
          blocked = 1'b1;
        end
        if (!blocked) begin
          if (rd_pend) begin
            ram_waddr = vox_addr(pnb.x, pnb.y, pnb.z);
            if (nb_solid) begin
              ram_we = 1'b1;
              if (item.cmd == CMD_CARVE) begin
                ram_wdata = {1'b1, ram_rdata[FACE_W-1:0] | far_bit(pdir)};
                if (ram_rdata[FACE_W-1:0] == '0) begin
                  if (pend_valid) begin
                    push = 1'b1;
                    push_data = pend;
                  end
                  pend_next = found;
                  pend_valid_next = 1'b1;
                end
              end else begin
                ram_wdata = {1'b1, ram_rdata[FACE_W-1:0] & ~far_bit(pdir)};
              end
            end else begin
              proc_bits = own_bit(pdir);
            end
          end
          if (dir == DIR_DONE) begin
            rd_pend_next = 1'b0;
            state_next = ST_FINISH;
          end else begin
            if (nb_ok) begin
              ram_re = 1'b1;
              ram_raddr = vox_addr(nb.x, nb.y, nb.z);
              rd_pend_next = 1'b1;
              pdir_next = dir;
            end else begin
              rd_pend_next = 1'b0;
              issue_bits = own_bit(dir);
            end
            dir_next = dir + DIR_W'(1);
          end
          mask_next = mask | proc_bits | issue_bits;
        end
      end

      ST_FINISH: begin
        case (item.cmd)
          CMD_READ: begin
            if (can_emit) begin
              push = 1'b1;
              push_data = '{kind: KIND_READ, out_x: item.pos_x, out_y: item.pos_y,
                            out_z: item.pos_z, faces: cur[FACE_W-1:0],
                            solid: cur[FACE_W], last: 1'b1};
              state_next = ST_IDLE;
            end
          end
          CMD_ADD: begin
            if (can_emit || cur[FACE_W-1:0] != '0 || mask == '0) begin
              ram_we = 1'b1;
              ram_wdata = {1'b1, mask};
              if (cur[FACE_W-1:0] == '0 && mask != '0) begin
                push = 1'b1;
                push_data = '{kind: KIND_VISIBLE, out_x: item.pos_x, out_y: item.pos_y,
                              out_z: item.pos_z, faces: mask, solid: 1'b1, last: 1'b1};
              end
              state_next = ST_IDLE;
            end
          end
          default: begin
            if (!pend_valid) begin
              state_next = ST_IDLE;
            end else if (can_emit) begin
              push = 1'b1;
              push_data = pend;
              push_data.last = 1'b1;
              pend_valid_next = 1'b0;
              state_next = ST_IDLE;
            end
          end
        endcase
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend <= 1'b0;
      pend_valid <= 1'b0;
      dir <= DIR_NX;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_addr <= clr_addr_next;
      rd_pend <= rd_pend_next;
      pend_valid <= pend_valid_next;
      dir <= dir_next;
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
    pdir <= pdir_next;
    mask <= mask_next;
    cur <= cur_next;
    pend <= pend_next;
    if (push) begin
      rsp <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_x <= EXTENT_RESET;
      ext_y <= EXTENT_RESET;
      ext_z <= EXTENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXTENT_X: ext_x <= cfg_data;
        REG_EXTENT_Y: ext_y <= cfg_data;
        REG_EXTENT_Z: ext_z <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/veft_ram.sv
// Generic synchronous RAM with one write port and one registered read port.
// Reads return the old contents on a same-address write. No dependencies.
`default_nettype none

module veft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/veft_checker.sv
// Port-level checker for the voxel exposed-face tracker, bound to the top level.
// Depends on veft_pkg and voxel_exposed_face_tracker_defines.svh.
`default_nettype none
`include "voxel_exposed_face_tracker_defines.svh"

module veft_checker
  import veft_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  `VEFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
  `VEFT_ASSERT_IMPL(a_clear_after_reset, $past(rst), req_stall && !rsp_valid, "busy expected after reset")
  `VEFT_ASSERT_IMPL(a_read_last, rsp_valid && rsp.kind == KIND_READ, rsp.last, "read reply not last")
  `VEFT_ASSERT_IMPL(a_visible_solid, rsp_valid && rsp.kind == KIND_VISIBLE, rsp.solid && rsp.faces != '0, "visible report without faces")

endmodule

bind voxel_exposed_face_tracker veft_checker u_checker (.*);

`default_nettype wire
